>>> rtl/mrpt_pkg.sv
package mrpt_pkg;

  localparam int NUMBER_WIDTH = 62;
  localparam int BASE_COUNT   = 12;
  localparam int TABLE_BASES  = 12;
  localparam int BASE_WIDTH   = 6;

  typedef enum logic [1:0] {
    MUL_ACC_B,
    MUL_B_B,
    MUL_X_X
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASS,
    ST_SHIFT,
    ST_BASE,
    ST_PCHK,
    ST_PWA,
    ST_PWB,
    ST_TEST,
    ST_SCHK,
    ST_SQW,
    ST_SQT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic     load;
    logic     shift_d;
    logic     init_pow;
    logic     next_base;
    logic     mul_start;
    mul_sel_e mul_sel;
  } cmd_t;

  typedef struct packed {
    logic n_le1;
    logic n_le3;
    logic n_even;
    logic d_even;
    logic base_ok;
    logic e_zero;
    logic e_lsb;
    logic mul_done;
    logic x_one;
    logic x_nm1;
    logic i_lt_r;
  } sts_t;

  function automatic logic [BASE_WIDTH-1:0] base_of(input logic [3:0] k);
    logic [BASE_WIDTH-1:0] b;
    case (k)
      4'd0:    b = 6'd2;
      4'd1:    b = 6'd3;
      4'd2:    b = 6'd5;
      4'd3:    b = 6'd7;
      4'd4:    b = 6'd11;
      4'd5:    b = 6'd13;
      4'd6:    b = 6'd17;
      4'd7:    b = 6'd19;
      4'd8:    b = 6'd23;
      4'd9:    b = 6'd29;
      4'd10:   b = 6'd31;
      4'd11:   b = 6'd37;
      default: b = 6'd0;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/mrpt_modmul.sv
module mrpt_modmul import mrpt_pkg::*; #(
  parameter int W = NUMBER_WIDTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] x_i,
  input  logic [W-1:0] y_i,
  input  logic [W-1:0] m_i,
  output logic         done_o,
  output logic [W-1:0] p_o
);

  logic [W-1:0] acc_q, add_q, y_q, m_q;
  logic         busy_q;
  logic [W:0]   sum, dbl;
  logic [W-1:0] acc_d, add_d;

  always_comb begin
    sum   = {1'b0, acc_q} + {1'b0, add_q};
    acc_d = (sum >= {1'b0, m_q}) ? W'(sum - {1'b0, m_q}) : sum[W-1:0];
    dbl   = {add_q, 1'b0};
    add_d = (dbl >= {1'b0, m_q}) ? W'(dbl - {1'b0, m_q}) : dbl[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && y_q == '0) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      add_q <= x_i;
      y_q   <= y_i;
      m_q   <= m_i;
    end else if (busy_q && y_q != '0) begin
      if (y_q[0]) acc_q <= acc_d;
      add_q <= add_d;
      y_q   <= y_q >> 1;
    end
  end

  assign done_o = busy_q && (y_q == '0);
  assign p_o    = acc_q;

endmodule

>>> rtl/mrpt_datapath.sv
module mrpt_datapath import mrpt_pkg::*; #(
  parameter int W  = NUMBER_WIDTH,
  parameter int NB = BASE_COUNT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [W-1:0] n_i,
  input  cmd_t         cmd_i,
  output sts_t         sts_o
);

  localparam int RW = $clog2(W + 1);
  localparam int KW = $clog2(NB + 1);

  logic [W-1:0]  n_q, d_q, acc_q, b_q, e_q;
  logic [RW-1:0] r_q, i_q;
  logic [KW-1:0] k_q;
  mul_sel_e      sel_q;
  logic [W-1:0]  base, op_x, op_y, prod;
  logic          mul_done;

  assign base = {{(W-BASE_WIDTH){1'b0}}, base_of(4'(k_q))};

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_ACC_B: begin op_x = acc_q; op_y = b_q;   end
      MUL_B_B:   begin op_x = b_q;   op_y = b_q;   end
      default:   begin op_x = acc_q; op_y = acc_q; end
    endcase
  end

  mrpt_modmul #(.W(W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .x_i     (op_x),
    .y_i     (op_y),
    .m_i     (n_q),
    .done_o  (mul_done),
    .p_o     (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= MUL_ACC_B;
    end else if (cmd_i.mul_start) begin
      sel_q <= cmd_i.mul_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q <= n_i;
      d_q <= n_i - W'(1);
      r_q <= '0;
      k_q <= '0;
    end
    if (cmd_i.shift_d) begin
      d_q <= d_q >> 1;
      r_q <= r_q + RW'(1);
    end
    if (cmd_i.next_base) k_q <= k_q + KW'(1);
    if (cmd_i.init_pow) begin
      acc_q <= W'(1);
      b_q   <= base;
      e_q   <= d_q;
      i_q   <= RW'(1);
    end else if (mul_done) begin
      case (sel_q)
        MUL_ACC_B: acc_q <= prod;
        MUL_B_B: begin
          b_q <= prod;
          e_q <= e_q >> 1;
        end
        default: begin
          acc_q <= prod;
          i_q   <= i_q + RW'(1);
        end
      endcase
    end
  end

  always_comb begin
    sts_o.n_le1    = n_q <= W'(1);
    sts_o.n_le3    = n_q <= W'(3);
    sts_o.n_even   = !n_q[0];
    sts_o.d_even   = !d_q[0];
    sts_o.base_ok  = (k_q < KW'(NB)) && (base < n_q);
    sts_o.e_zero   = e_q == '0;
    sts_o.e_lsb    = e_q[0];
    sts_o.mul_done = mul_done;
    sts_o.x_one    = acc_q == W'(1);
    sts_o.x_nm1    = acc_q == (n_q - W'(1));
    sts_o.i_lt_r   = i_q < r_q;
  end

endmodule

>>> rtl/mrpt_ctrl.sv
module mrpt_ctrl import mrpt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic result_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_ACC_B;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        state_d    = ST_CLASS;
      end
      ST_CLASS: begin
        if (sts_i.n_le1 || (sts_i.n_even && !sts_i.n_le3)) begin
          res_d = 1'b0; state_d = ST_DONE;
        end else if (sts_i.n_le3) begin
          res_d = 1'b1; state_d = ST_DONE;
        end else begin
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (sts_i.d_even) cmd_o.shift_d = 1'b1;
        else state_d = ST_BASE;
      end
      ST_BASE: begin
        if (!sts_i.base_ok) begin
          res_d = 1'b1; state_d = ST_DONE;
        end else begin
          cmd_o.init_pow = 1'b1;
          state_d        = ST_PCHK;
        end
      end
      ST_PCHK: begin
        if (sts_i.e_zero) begin
          state_d = ST_TEST;
        end else begin
          cmd_o.mul_start = 1'b1;
          if (sts_i.e_lsb) begin
            cmd_o.mul_sel = MUL_ACC_B; state_d = ST_PWA;
          end else begin
            cmd_o.mul_sel = MUL_B_B;   state_d = ST_PWB;
          end
        end
      end
      ST_PWA: if (sts_i.mul_done) begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MUL_B_B;
        state_d         = ST_PWB;
      end
      ST_PWB: if (sts_i.mul_done) state_d = ST_PCHK;
      ST_TEST: begin
        if (sts_i.x_one || sts_i.x_nm1) begin
          cmd_o.next_base = 1'b1; state_d = ST_BASE;
        end else begin
          state_d = ST_SCHK;
        end
      end
      ST_SCHK: begin
        if (sts_i.i_lt_r) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_X_X;
          state_d         = ST_SQW;
        end else begin
          res_d = 1'b0; state_d = ST_DONE;
        end
      end
      ST_SQW: if (sts_i.mul_done) state_d = ST_SQT;
      ST_SQT: begin
        if (sts_i.x_one) begin
          res_d = 1'b0; state_d = ST_DONE;
        end else if (sts_i.x_nm1) begin
          cmd_o.next_base = 1'b1; state_d = ST_BASE;
        end else begin
          state_d = ST_SCHK;
        end
      end
      ST_DONE: if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = state_q == ST_DONE;
  assign result_o    = res_q;

endmodule

>>> rtl/miller_rabin_primality_test.sv
// Deterministic Miller-Rabin primality test of one unsigned candidate per word, with the
// fixed bases 2 through 37 (first BASE_COUNT of them, stopping at the first base not below
// the candidate). One candidate is in work at a time. Run time is set by a single
// shift-and-add modular multiplier that steps through its second operand bit by bit,
// with up to about 2*NUMBER_WIDTH products per base; small, even and easily rejected
// candidates finish sooner.
module miller_rabin_primality_test import mrpt_pkg::*; #(
  parameter int NUMBER_WIDTH_P = NUMBER_WIDTH,
  parameter int BASE_COUNT_P   = BASE_COUNT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // candidate
  input  logic [((NUMBER_WIDTH_P+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // is_prime
  output logic [7:0]                          m_axis_tdata_o
);

  cmd_t cmd;
  sts_t sts;
  logic result;

  mrpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (result),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mrpt_datapath #(.W(NUMBER_WIDTH_P), .NB(BASE_COUNT_P)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .n_i    (s_axis_tdata_i[NUMBER_WIDTH_P-1:0]),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  assign m_axis_tdata_o = {7'd0, result};

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input taken while result pending");

  a_accept_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (!m_axis_tvalid_o && !s_axis_tready_o))
    else $error("result or ready right after accept");

  a_mul_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul_start |-> !s_axis_tready_o)
    else $error("multiply started while idle");

endmodule
